/* rtl/bse_pkg.sv */
// bse_pkg: shared types and constants of the battery state-of-charge estimator.
// No dependencies; imported by bse_dp, bse_ctrl and the top level.
package bse_pkg;

  localparam logic [13:0] PCT_FULL = 14'd10000;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_CELL = 2'd0;
  localparam logic [1:0] CFG_MAX_CELL = 2'd1;
  localparam logic [1:0] CFG_SIM_DELTA = 2'd2;
  localparam logic [1:0] CFG_TAU = 2'd3;

  localparam logic [12:0] MIN_CELL_RST = 13'd3000;
  localparam logic [12:0] MAX_CELL_RST = 13'd4200;
  localparam logic [9:0] SIM_DELTA_RST = 10'd0;
  localparam logic [15:0] TAU_RST = 16'd5000;

  typedef struct packed {
    logic [12:0] min_cell_mv;
    logic [12:0] max_cell_mv;
    logic [9:0] sim_delta_mv;
    logic [15:0] tau_ms;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input transaction
    logic prep;      // cell count and pack maximum update
    logic calc;      // floor, span, numerator
    logic div_go;    // start divider
    logic div_sel;   // 0 raw percentage, 1 smoothing weight
    logic take_raw;  // capture raw result, seed smoother on first sample
    logic mul_go;    // start serial multiply
    logic commit;    // smoother update
    logic out_load;  // fill output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op;
    logic span_pos;
    logic have_sample;
    logic div_busy;
    logic mul_busy;
  } sts_t;

endpackage

/* rtl/bse_div.sv */
// bse_div: restoring serial divider, one quotient bit per cycle.
// Depends on nothing; used by bse_dp.
module bse_div #(
  parameter int NW = 48,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [DW:0] sh;
  logic ge;

  assign sh = {rem, quotient[NW-1]};
  assign ge = sh >= {1'b0, dvs};
  assign busy = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quotient <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? DW'(sh - {1'b0, dvs}) : sh[DW-1:0];
      quotient <= {quotient[NW-2:0], ge};
    end
  end

endmodule

/* rtl/bse_dp.sv */
// bse_dp: datapath - cell detection, calibration, span, divider, serial
// multiply and smoother. Depends on bse_pkg and bse_div.
module bse_dp
  import bse_pkg::*;
#(
  parameter int F = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        in_op,
  input  logic [14:0] in_pack_mv,
  input  logic [31:0] in_time_ms,
  output logic [13:0] out_soc_centi,
  output logic        out_soc_valid,
  output logic [1:0]  out_cells,
  output logic [14:0] out_max_pack_mv
);

  localparam int NW = 32 + F;
  localparam int SW = 14 + F;
  localparam int MCW = $clog2(F + 1);

  // transaction
  logic op;
  logic [14:0] v;
  logic [31:0] now;

  // block state
  logic [1:0] cell_count, ticks;
  logic [14:0] pack_max;
  logic have_sample;
  logic [SW-1:0] smoothed;
  logic [31:0] last_time;

  // working registers
  logic signed [17:0] span, num;
  logic [13:0] raw, soc;
  logic [F-1:0] alpha;
  logic [SW:0] acc;
  logic [SW-1:0] diff;
  logic dir;
  logic [MCW-1:0] mcnt;

  // cell detection
  logic [15:0] v2, max3, max5;
  logic [1:0] n_det, n_new;
  logic [1:0] ticks_new;
  assign v2 = {v, 1'b0};
  assign max3 = 16'(cfg.max_cell_mv) * 16'd3;
  assign max5 = 16'(cfg.max_cell_mv) * 16'd5;

  always_comb begin
    if (v2 < max3) n_det = 2'd1;
    else if (v2 < max5) n_det = 2'd2;
    else n_det = 2'd3;
    n_new = cell_count;
    ticks_new = ticks;
    priority if (cell_count == 2'd0 || cell_count == n_det) begin
      n_new = n_det;
    end else if (ticks < 2'd2) begin
      ticks_new = ticks + 2'd1;
    end else begin
      n_new = n_det;
      ticks_new = 2'd0;
    end
  end

  // calibration
  logic signed [13:0] cell_sim;
  logic signed [16:0] sim;
  logic [14:0] nmax_new, seed_max, meas_max;
  assign cell_sim = $signed({1'b0, cfg.max_cell_mv}) - $signed({4'b0, cfg.sim_delta_mv});
  assign sim = 17'(cell_sim) * $signed({15'b0, n_new});
  assign nmax_new = 15'(n_new) * 15'(cfg.max_cell_mv);
  always_comb begin
    seed_max = sim[16] ? 15'd0 : sim[14:0];
    if (v > seed_max) seed_max = v;
    meas_max = (v > pack_max && v <= nmax_new) ? v : pack_max;
  end

  // floor and span from the updated count and maximum
  logic signed [17:0] ceil_mv, delta, floor_adj, nmin;
  assign ceil_mv = $signed({3'b0, 15'(cell_count) * 15'(cfg.max_cell_mv)});
  assign nmin = $signed({3'b0, 15'(cell_count) * 15'(cfg.min_cell_mv)});
  always_comb begin
    delta = ceil_mv - $signed({3'b0, pack_max});
    if (delta < 0) delta = -delta;
    floor_adj = nmin - delta;
  end

  // divider operands
  logic [30:0] raw_num;
  logic [15:0] tau_eff;
  logic [31:0] dt;
  logic [NW-1:0] div_a, quot;
  logic [32:0] div_b;
  logic div_busy;
  assign raw_num = (num > 0 ? 31'(num[16:0]) * 31'(PCT_FULL) : 31'd0)
                   + 31'(span[16:1]);
  assign tau_eff = cfg.tau_ms == 16'd0 ? 16'd1 : cfg.tau_ms;
  assign dt = now - last_time;
  assign div_a = cmd.div_sel ? {dt, {F{1'b0}}} : NW'(raw_num);
  assign div_b = cmd.div_sel ? 33'(tau_eff) + 33'(dt) : 33'(span[16:0]);

  bse_div #(.NW(NW), .DW(33)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_go), .dividend(div_a),
    .divisor(div_b), .busy(div_busy), .quotient(quot)
  );

  logic [13:0] raw_c;
  assign raw_c = (quot > NW'(PCT_FULL)) ? PCT_FULL : quot[13:0];

  // smoother
  logic [SW-1:0] target, sm_next;
  logic [SW:0] rnd;
  logic [14:0] rnd_q;
  assign target = {raw, {F{1'b0}}};
  assign sm_next = dir ? SW'(smoothed + acc[SW-1:0]) : SW'(smoothed - acc[SW-1:0]);
  assign rnd = {1'b0, sm_next} + (SW + 1)'(1 << (F - 1));
  assign rnd_q = rnd[SW:F];

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count <= 2'd0;
      ticks <= 2'd0;
      pack_max <= 15'd0;
      have_sample <= 1'b0;
      smoothed <= '0;
      last_time <= 32'd0;
      mcnt <= '0;
    end else begin
      if (cmd.prep) begin
        cell_count <= n_new;
        ticks <= ticks_new;
        pack_max <= op ? meas_max : seed_max;
      end
      if (cmd.take_raw && !have_sample) begin
        have_sample <= 1'b1;
        smoothed <= {raw_c, {F{1'b0}}};
        last_time <= now;
      end
      if (cmd.mul_go) mcnt <= MCW'(F);
      else if (mcnt != '0) mcnt <= mcnt - 1'b1;
      if (cmd.commit) begin
        smoothed <= sm_next;
        last_time <= now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_op;
      v <= in_pack_mv;
      now <= in_time_ms;
    end
    if (cmd.prep) soc <= 14'd0;
    if (cmd.calc) begin
      span <= $signed({3'b0, pack_max}) - floor_adj;
      num <= $signed({3'b0, v}) - floor_adj;
    end
    if (cmd.take_raw) begin
      raw <= raw_c;
      if (!have_sample) soc <= raw_c;
    end
    if (cmd.mul_go) begin
      alpha <= quot[F-1:0];
      dir <= target >= smoothed;
      diff <= target >= smoothed ? SW'(target - smoothed) : SW'(smoothed - target);
      acc <= '0;
    end else if (mcnt != '0) begin
      acc <= SW'(({1'b0, acc} + (alpha[0] ? (SW + 2)'(diff) : '0)) >> 1);
      alpha <= alpha >> 1;
    end
    if (cmd.commit) soc <= rnd_q > 15'(PCT_FULL) ? PCT_FULL : rnd_q[13:0];
    if (cmd.out_load) begin
      out_soc_centi <= soc;
      out_soc_valid <= op;
      out_cells <= cell_count;
      out_max_pack_mv <= pack_max;
    end
  end

  assign sts.op = op;
  assign sts.span_pos = span > 0;
  assign sts.have_sample = have_sample;
  assign sts.div_busy = div_busy;
  assign sts.mul_busy = mcnt != '0;

endmodule

/* rtl/bse_ctrl.sv */
// bse_ctrl: sequencer of the estimator and owner of the stream handshakes.
// Depends on bse_pkg; drives bse_dp through cmd_t.
module bse_ctrl
  import bse_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PREP = 4'd1;
  localparam logic [3:0] ST_CALC = 4'd2;
  localparam logic [3:0] ST_CHK = 4'd3;
  localparam logic [3:0] ST_DIVS1 = 4'd4;
  localparam logic [3:0] ST_DIVW1 = 4'd5;
  localparam logic [3:0] ST_DIVS2 = 4'd6;
  localparam logic [3:0] ST_DIVW2 = 4'd7;
  localparam logic [3:0] ST_MULS = 4'd8;
  localparam logic [3:0] ST_MULW = 4'd9;
  localparam logic [3:0] ST_COMMIT = 4'd10;
  localparam logic [3:0] ST_FIN = 4'd11;

  logic [3:0] state, state_next;
  logic out_free;

  assign s_tready = state == ST_IDLE;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) begin
        cmd.load = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        state_next = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        state_next = ST_CHK;
      end
      ST_CHK: state_next = (sts.op && sts.span_pos) ? ST_DIVS1 : ST_FIN;
      ST_DIVS1: begin
        cmd.div_go = 1'b1;
        state_next = ST_DIVW1;
      end
      ST_DIVW1: if (!sts.div_busy) begin
        cmd.take_raw = 1'b1;
        state_next = sts.have_sample ? ST_DIVS2 : ST_FIN;
      end
      ST_DIVS2: begin
        cmd.div_go = 1'b1;
        cmd.div_sel = 1'b1;
        state_next = ST_DIVW2;
      end
      ST_DIVW2: begin
        cmd.div_sel = 1'b1;
        if (!sts.div_busy) state_next = ST_MULS;
      end
      ST_MULS: begin
        cmd.mul_go = 1'b1;
        state_next = ST_MULW;
      end
      ST_MULW: if (!sts.mul_busy) state_next = ST_COMMIT;
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: if (out_free) begin
        cmd.out_load = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_PREP) else $error("accept not followed by prep");
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIVS1 |=> sts.div_busy) else $error("divider did not start");
  a_mul_runs: assert property (@(posedge clk) disable iff (rst)
    state == ST_MULS |=> sts.mul_busy) else $error("multiplier did not start");
  a_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && out_free |=> m_tvalid && state == ST_IDLE)
    else $error("result not presented");

endmodule

/* rtl/battery_soc_estimator.sv */
// battery_soc_estimator: top level - configuration registers, controller and
// datapath. Depends on bse_pkg, bse_ctrl, bse_dp (and bse_div below it).
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | tdata pack_mv, time_ms; tuser operation
//  m_      | out       | m_tvalid/m_tready  | tdata soc_centi, cells, max_pack_mv;
//          |           |                    | tuser soc_valid
//  cfg_    | in        | cfg_we             | cfg_addr index, cfg_data value
//
// Work: a seed or a reading with no positive span skips the arithmetic; a first
// measure runs the shared serial divider once; a later measure runs it twice and
// then the bit-serial smoothing multiply. One transaction is worked on at a time.
// Reset (rst, synchronous) loads register defaults and clears count, maximum and
// smoother state. A stalled result sits in the output register; the next input
// transaction is taken meanwhile and waits only at the end of its own work.
module battery_soc_estimator
  import bse_pkg::*;
#(
  parameter int SMOOTH_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [14:0] pack_mv, [46:15] time_ms, [47] zero
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [13:0] soc_centi, [15:14] cells,
                                 // [30:16] max_pack_mv, [31] zero
  output logic        m_tuser,   // [0] soc_valid
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  logic [13:0] soc_centi;
  logic [1:0] cells;
  logic [14:0] max_pack_mv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_cell_mv <= MIN_CELL_RST;
      cfg.max_cell_mv <= MAX_CELL_RST;
      cfg.sim_delta_mv <= SIM_DELTA_RST;
      cfg.tau_ms <= TAU_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MIN_CELL: cfg.min_cell_mv <= cfg_data[12:0];
        CFG_MAX_CELL: cfg.max_cell_mv <= cfg_data[12:0];
        CFG_SIM_DELTA: cfg.sim_delta_mv <= cfg_data[9:0];
        CFG_TAU: cfg.tau_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  bse_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .sts(sts), .cmd(cmd)
  );

  bse_dp #(.F(SMOOTH_FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .sts(sts),
    .in_op(s_tuser), .in_pack_mv(s_tdata[14:0]), .in_time_ms(s_tdata[46:15]),
    .out_soc_centi(soc_centi), .out_soc_valid(m_tuser), .out_cells(cells),
    .out_max_pack_mv(max_pack_mv)
  );

  assign m_tdata = {1'b0, max_pack_mv, cells, soc_centi};

endmodule

/* verif/tb_top.sv */
// tb_top: self-checking testbench for battery_soc_estimator.
// Depends on bse_pkg and the RTL; a built-in predictor, a queued driver and a monitor.
`timescale 1ns / 100ps

module tb_top;
  import bse_pkg::*;

  localparam int FB = 16;

  typedef struct {
    logic        op;
    logic [14:0] mv;
    logic [31:0] tms;
  } reading_t;

  typedef struct {
    logic [13:0] soc;
    logic        vld;
    logic [1:0]  cells;
    logic [14:0] pmax;
  } soc_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_data = '0;

  battery_soc_estimator #(.SMOOTH_FRAC_BITS(FB)) i_dut (.*);

  always #5 clk = ~clk;

  // predictor state: own copy of configuration and estimator state
  longint unsigned p_min, p_max, p_delta, p_tau;
  longint unsigned p_cells, p_ticks, p_pmax, p_have, p_smooth, p_last;

  reading_t pending_q[$];
  soc_res_t soc_expect_q[$];
  int       n_errors = 0;
  bit       no_idle = 1'b0;  // long stretch with no idling on either side
  bit       stim_done = 1'b0;
  bit       in_taken = 1'b0; // input transaction accepted at the last rising edge

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic void predictor_reset();
    p_min = 3000; p_max = 4200; p_delta = 0; p_tau = 5000;
    p_cells = 0; p_ticks = 0; p_pmax = 0; p_have = 0; p_smooth = 0; p_last = 0;
  endfunction

  function automatic soc_res_t predict_soc(reading_t r);
    soc_res_t        res;
    longint unsigned v, n, soc, raw, dt, tau, alpha, target, rnd;
    longint          sim, m, delta, floor_adj, span, num;
    v = r.mv;
    // cell count with debounced change; agreement does not clear the ticks
    if (2 * v < 3 * p_max) n = 1;
    else if (2 * v < 5 * p_max) n = 2;
    else n = 3;
    if (p_cells == 0 || p_cells == n) p_cells = n;
    else if (p_ticks < 2) p_ticks++;
    else begin
      p_cells = n;
      p_ticks = 0;
    end
    n = p_cells;
    soc = 0;
    if (!r.op) begin
      sim = longint'(n) * (longint'(p_max) - longint'(p_delta));
      m = longint'(v) > sim ? longint'(v) : sim;
      if (m > 32767) m = 32767;
      p_pmax = m;
    end else begin
      if (v > p_pmax && v <= n * p_max) p_pmax = v;
      delta = longint'(n * p_max) - longint'(p_pmax);
      if (delta < 0) delta = -delta;
      floor_adj = longint'(n * p_min) - delta;
      span = longint'(p_pmax) - floor_adj;
      if (span > 0) begin
        num = longint'(v) - floor_adj;
        if (num <= 0) raw = 0;
        else begin
          raw = (longint'(num) * 10000 + span / 2) / span;
          if (raw > 10000) raw = 10000;
        end
        if (!p_have) begin
          p_have = 1;
          p_smooth = raw << FB;
          soc = raw;
        end else begin
          dt = (longint'(r.tms) - longint'(p_last)) & 64'hFFFF_FFFF;
          tau = p_tau ? p_tau : 1;
          alpha = (dt << FB) / (tau + dt);
          target = raw << FB;
          if (target >= p_smooth) p_smooth += (alpha * (target - p_smooth)) >> FB;
          else p_smooth -= (alpha * (p_smooth - target)) >> FB;
          rnd = (p_smooth + (64'd1 << (FB - 1))) >> FB;
          soc = rnd > 10000 ? 10000 : rnd;
        end
        p_last = r.tms;
      end
    end
    res.soc = soc[13:0];
    res.vld = r.op;
    res.cells = n[1:0];
    res.pmax = p_pmax[14:0];
    return res;
  endfunction

  // note an input handshake at the rising edge for the driver
  always @(posedge clk) begin
    in_taken <= !rst && s_tvalid && s_tready;
  end

  // driver: one transaction at a time from pending_q, changes on falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        // accepted at the last rising edge: predict now
        soc_expect_q.push_back(predict_soc(pending_q.pop_front()));
      end
      // an offered transaction is held until it is taken
      if (pending_q.size() > 0 &&
          ((s_tvalid && !in_taken) || no_idle || $urandom_range(99) >= 19)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pending_q[0].tms, pending_q[0].mv};
        s_tuser  <= pending_q[0].op;
      end else begin
        s_tvalid <= 1'b0;
      end
      m_tready <= no_idle || $urandom_range(99) >= 19;
    end
  end

  // monitor: sample at the rising edge
  always @(posedge clk) begin
    soc_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (soc_expect_q.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, 0);
      end else begin
        want = soc_expect_q.pop_front();
        if (m_tdata[13:0] !== want.soc) report_mismatch("soc_centi", m_tdata[13:0], want.soc);
        if (m_tuser !== want.vld) report_mismatch("soc_valid", m_tuser, want.vld);
        if (m_tdata[15:14] !== want.cells) report_mismatch("cells", m_tdata[15:14], want.cells);
        if (m_tdata[30:16] !== want.pmax)
          report_mismatch("max_pack_mv", m_tdata[30:16], want.pmax);
      end
    end
  end

  task automatic queue_reading(input logic op, input logic [14:0] mv, input logic [31:0] tms);
    reading_t r;
    r.op = op; r.mv = mv; r.tms = tms;
    pending_q.push_back(r);
  endtask

  // wait until the block has drained everything queued
  task automatic drain();
    while (pending_q.size() > 0 || s_tvalid || soc_expect_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MIN_CELL:  p_min = val & 16'h1FFF;
      CFG_MAX_CELL:  p_max = val & 16'h1FFF;
      CFG_SIM_DELTA: p_delta = val & 16'h03FF;
      default:       p_tau = val;
    endcase
  endtask

  // plausible readings around the current cell limits with random content
  task automatic random_phase(input int cnt);
    int unsigned base_t, c, lo, hi, mv;
    base_t = $urandom();
    for (int i = 0; i < cnt; i++) begin
      c = $urandom_range(3, 1);
      if ($urandom_range(9) == 0) begin
        mv = $urandom_range(32767);
      end else begin
        lo = 32'(c * p_min);
        hi = 32'(c * p_max + 200);
        if (lo > hi) lo = 0;
        if (hi > 32767) hi = 32767;
        mv = $urandom_range(hi, lo > 200 ? lo - 200 : 0);
      end
      base_t += ($urandom_range(3) == 0) ? $urandom() : $urandom_range(3000);
      queue_reading($urandom_range(7) != 0, mv[14:0], base_t);
    end
  endtask

  initial begin
    predictor_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: extremes, seed before measure, debounce, zero span, wrap
    queue_reading(1'b1, 15'd12000, 32'd0);        // measure before any seed
    queue_reading(1'b0, 15'd12600, 32'd10);
    queue_reading(1'b1, 15'd12000, 32'd20);       // measure against the seeded maximum
    queue_reading(1'b1, 15'd11000, 32'd1020);
    queue_reading(1'b1, 15'd4000, 32'd2000);      // disagreeing counts
    queue_reading(1'b1, 15'd12000, 32'd2100);     // agreeing, ticks kept
    queue_reading(1'b1, 15'd4000, 32'd2200);
    queue_reading(1'b1, 15'd4000, 32'd2300);      // count changes
    queue_reading(1'b1, 15'd0, 32'd2400);
    queue_reading(1'b1, 15'd32767, 32'hFFFF_FFF0);
    queue_reading(1'b1, 15'd12000, 32'd5);        // timestamp wrap
    queue_reading(1'b0, 15'd32767, 32'hFFFF_FFFF);
    queue_reading(1'b1, 15'd32767, 32'd100);
    queue_reading(1'b1, 15'd8000, 32'd100);       // zero dt
    drain();   // sender holds off until every result has come
    write_reg(CFG_MAX_CELL, 16'd5000);
    write_reg(CFG_SIM_DELTA, 16'd1000);
    write_reg(CFG_TAU, 16'd0);
    write_reg(CFG_MIN_CELL, 16'd5000);            // empty equals full: no span
    queue_reading(1'b0, 15'd15000, 32'd1);
    queue_reading(1'b1, 15'd14000, 32'd2);
    queue_reading(1'b1, 15'd15000, 32'd3);
    drain();
    write_reg(CFG_MIN_CELL, 16'd0);
    write_reg(CFG_MAX_CELL, 16'd1);
    write_reg(CFG_TAU, 16'd65535);
    queue_reading(1'b0, 15'd0, 32'd0);            // negative simulated maximum
    queue_reading(1'b1, 15'd1, 32'd70000);
    queue_reading(1'b1, 15'd3, 32'd80000);
    drain();
    // random phases across several settings
    write_reg(CFG_MIN_CELL, 16'd3000);
    write_reg(CFG_MAX_CELL, 16'd4200);
    write_reg(CFG_SIM_DELTA, 16'd100);
    write_reg(CFG_TAU, 16'd5000);
    no_idle = 1'b1;
    random_phase(160);
    drain();
    no_idle = 1'b0;
    write_reg(CFG_MIN_CELL, 16'd8191);
    write_reg(CFG_MAX_CELL, 16'd8191);
    write_reg(CFG_SIM_DELTA, 16'd1023);
    write_reg(CFG_TAU, 16'd1);
    random_phase(160);
    drain();
    write_reg(CFG_MIN_CELL, 16'($urandom_range(4000, 2500)));
    write_reg(CFG_MAX_CELL, 16'($urandom_range(5000, 3600)));
    write_reg(CFG_SIM_DELTA, 16'($urandom_range(1000)));
    write_reg(CFG_TAU, 16'($urandom_range(65535)));
    random_phase(160);
    drain();
    write_reg(CFG_MIN_CELL, 16'd2000);
    write_reg(CFG_MAX_CELL, 16'd3000);
    write_reg(CFG_SIM_DELTA, 16'd500);
    write_reg(CFG_TAU, 16'd200);
    random_phase(150);
    drain();
    if (n_errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // watchdog: a time bound on all ~650 items, stalls included
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
